/* rtl/core/ffba_pkg.sv */
// Shared constants, types and helpers for the first-fit block allocator.
// Depends on nothing; every allocator module imports it.
`default_nettype none
package ffba_pkg;

    // Pool geometry
    localparam int POOL_CELLS = 8192;
    localparam int CELL_BYTES = 8;
    localparam int GROW_BYTES = 1024;
    localparam int GROW_CELLS = (GROW_BYTES + CELL_BYTES - 1) / CELL_BYTES;
    localparam int CELL_SHIFT = $clog2(CELL_BYTES);

    // Field widths
    localparam int IDX_W   = 13;
    localparam int LEN_W   = 15;
    localparam int HDR_W   = IDX_W + LEN_W;
    localparam int JRN_W   = IDX_W + HDR_W;
    localparam int KIND_W  = 2;
    localparam int BYTES_W = 15;
    localparam int ST_W    = 3;
    localparam int LIM_W   = 14;
    localparam int NW_W    = BYTES_W - CELL_SHIFT + 1;
    localparam int CNT_W   = $clog2(POOL_CELLS + GROW_CELLS) + 2;
    localparam int SW_W    = 18;
    localparam int JPTR_W  = IDX_W + 1;

    // Request kinds
    localparam logic [KIND_W-1:0] K_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] K_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] K_RESIZE = 2'd2;
    localparam logic [KIND_W-1:0] K_TRUNC  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED  = 3'd1;
    localparam logic [ST_W-1:0] ST_NULL_TRUNC = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_BUSY   = 3'd3;
    localparam logic [ST_W-1:0] ST_TOO_LARGE  = 3'd4;

    // Datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_SNAP     = 5'd2;
    localparam logic [OP_W-1:0] OP_REL_RD   = 5'd3;
    localparam logic [OP_W-1:0] OP_REL_EV   = 5'd4;
    localparam logic [OP_W-1:0] OP_TR_RD    = 5'd5;
    localparam logic [OP_W-1:0] OP_TR_EV    = 5'd6;
    localparam logic [OP_W-1:0] OP_FF_START = 5'd7;
    localparam logic [OP_W-1:0] OP_WALK_RD  = 5'd8;
    localparam logic [OP_W-1:0] OP_WALK_EV  = 5'd9;
    localparam logic [OP_W-1:0] OP_MERGE_RD = 5'd10;
    localparam logic [OP_W-1:0] OP_MERGE_EV = 5'd11;
    localparam logic [OP_W-1:0] OP_FIT      = 5'd12;
    localparam logic [OP_W-1:0] OP_GNEED    = 5'd13;
    localparam logic [OP_W-1:0] OP_GSTEP    = 5'd14;
    localparam logic [OP_W-1:0] OP_GW1      = 5'd15;
    localparam logic [OP_W-1:0] OP_GW2      = 5'd16;
    localparam logic [OP_W-1:0] OP_GW3      = 5'd17;
    localparam logic [OP_W-1:0] OP_MB1      = 5'd18;
    localparam logic [OP_W-1:0] OP_MB2      = 5'd19;
    localparam logic [OP_W-1:0] OP_FFA_RD   = 5'd20;
    localparam logic [OP_W-1:0] OP_FFA_EV   = 5'd21;
    localparam logic [OP_W-1:0] OP_RST_RD   = 5'd22;
    localparam logic [OP_W-1:0] OP_RST_WR   = 5'd23;
    localparam logic [OP_W-1:0] OP_RST_DONE = 5'd24;
    localparam logic [OP_W-1:0] OP_FIN      = 5'd25;

    // Sentinel header: next 0, length minus one
    localparam logic [HDR_W-1:0] SENT_HDR = {{IDX_W{1'b0}}, {LEN_W{1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            st_we;
        logic [ST_W-1:0] st_val;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              bytes_zero;
        logic              valid;
        logic              p_ge_sent;
        logic              rd_pos;
        logic              rd_neg;
        logic              merge_ok;
        logic              fit;
        logic              grow_over;
        logic              grow_short;
        logic              tr_big;
        logic              p_is_ff;
        logic              ff_lt_sent;
        logic              jptr_zero;
    } flags_t;

    // Next block of p, with a broken link clamped to the sentinel
    function automatic logic [IDX_W-1:0] follow(input logic [IDX_W-1:0] p,
                                                input logic [IDX_W-1:0] n,
                                                input logic [IDX_W-1:0] sent);
        logic [IDX_W-1:0] r;
        r = ((n <= p) || (n > sent)) ? sent : n;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
// Usage:
//   Requests: raise start with kind, handle and request_bytes; the beat is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high until the request is finished.
//   Results: done is high for exactly one cycle with result_handle, status
//   and the copy fields; the receiver takes it in that cycle and cannot stall.
//   Configuration: pool_limit_we with pool_limit_wdata writes the pool limit;
//   write it only while the block is idle.
// Operation:
//   One request at a time. An allocate reads a header for each block walked
//   and for each merge, since every header goes through the one registered
//   read port of the header store. A grow rounds up in grow steps and then
//   writes three headers; an exhausted pool undoes the header writes held in
//   the journal.
// Reset:
//   rst_n clears the pointers, the pool limit (8192 cells) and the sequencer;
//   the header at cell 0 reads as the sentinel until first written, so no
//   clearing pass is needed and the block accepts a request at once.
`default_nettype none
module first_fit_block_allocator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ffba_pkg::KIND_W-1:0]   kind,
    input  wire logic [ffba_pkg::IDX_W-1:0]    handle,
    input  wire logic [ffba_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic                          pool_limit_we,
    input  wire logic [ffba_pkg::LIM_W-1:0]    pool_limit_wdata,
    output logic                               done,
    output logic [ffba_pkg::IDX_W-1:0]         result_handle,
    output logic [ffba_pkg::ST_W-1:0]          status,
    output logic [ffba_pkg::IDX_W-1:0]         copy_source,
    output logic [ffba_pkg::IDX_W-1:0]         copy_target,
    output logic [ffba_pkg::IDX_W-1:0]         copy_cells
);
    import ffba_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    // Sequencer
    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Header store and working registers
    ffba_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flags         (flags),
        .in_kind       (kind),
        .in_handle     (handle),
        .in_bytes      (request_bytes),
        .cfg_we        (pool_limit_we),
        .cfg_wdata     (pool_limit_wdata),
        .done          (done),
        .result_handle (result_handle),
        .status        (status),
        .copy_source   (copy_source),
        .copy_target   (copy_target),
        .copy_cells    (copy_cells)
    );

endmodule
`default_nettype wire

/* rtl/core/ffba_ctrl.sv */
// Sequencer of the first-fit allocator: walks the request through its steps.
// Depends on ffba_pkg; drives ffba_datapath through cmd_t and reads flags_t.
`default_nettype none
module ffba_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ffba_pkg::flags_t flags,
    output ffba_pkg::cmd_t       cmd,
    output logic                 busy
);
    import ffba_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_REL_RD   = 5'd2;
    localparam logic [4:0] S_REL_EV   = 5'd3;
    localparam logic [4:0] S_TR_RD    = 5'd4;
    localparam logic [4:0] S_TR_EV    = 5'd5;
    localparam logic [4:0] S_FF_START = 5'd6;
    localparam logic [4:0] S_WALK     = 5'd7;
    localparam logic [4:0] S_WALK_EV  = 5'd8;
    localparam logic [4:0] S_MCHK     = 5'd9;
    localparam logic [4:0] S_MEV      = 5'd10;
    localparam logic [4:0] S_FIT      = 5'd11;
    localparam logic [4:0] S_GNEED    = 5'd12;
    localparam logic [4:0] S_GSTEP    = 5'd13;
    localparam logic [4:0] S_GW1      = 5'd14;
    localparam logic [4:0] S_GW2      = 5'd15;
    localparam logic [4:0] S_GW3      = 5'd16;
    localparam logic [4:0] S_MB1      = 5'd17;
    localparam logic [4:0] S_MB2      = 5'd18;
    localparam logic [4:0] S_FFA      = 5'd19;
    localparam logic [4:0] S_FFA_EV   = 5'd20;
    localparam logic [4:0] S_RST      = 5'd21;
    localparam logic [4:0] S_RST_WR   = 5'd22;
    localparam logic [4:0] S_FIN      = 5'd23;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Choose the step and the operation it issues
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, st_we: 1'b0, st_val: ST_OK};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (flags.kind)
                    K_ALLOC:
                    begin
                        if (flags.bytes_zero)
                            state_next = S_FIN;
                        else
                        begin
                            cmd.op     = OP_SNAP;
                            state_next = S_FF_START;
                        end
                    end
                    K_FREE:
                        state_next = flags.valid ? S_REL_RD : S_FIN;
                    K_RESIZE:
                    begin
                        if (!flags.bytes_zero)
                            cmd.op = OP_SNAP;
                        state_next = S_REL_RD;
                    end
                    default:
                    begin
                        if (!flags.valid)
                        begin
                            cmd.st_we  = 1'b1;
                            cmd.st_val = ST_NULL_TRUNC;
                            state_next = S_FIN;
                        end
                        else if (flags.bytes_zero)
                            state_next = S_REL_RD;
                        else
                            state_next = S_TR_RD;
                    end
                endcase
            end
            S_REL_RD:
            begin
                cmd.op     = OP_REL_RD;
                state_next = S_REL_EV;
            end
            S_REL_EV:
            begin
                cmd.op     = OP_REL_EV;
                state_next = (flags.kind == K_RESIZE && !flags.bytes_zero) ? S_FF_START : S_FIN;
            end
            S_TR_RD:
            begin
                cmd.op     = OP_TR_RD;
                state_next = S_TR_EV;
            end
            S_TR_EV:
            begin
                if (!flags.rd_neg)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = ST_NOT_BUSY;
                    state_next = S_FIN;
                end
                else if (flags.tr_big)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = ST_TOO_LARGE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_TR_EV;
                    state_next = S_MB1;
                end
            end
            S_FF_START:
            begin
                cmd.op     = OP_FF_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (flags.p_ge_sent)
                    state_next = S_GNEED;
                else
                begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_WALK_EV;
                end
            end
            S_WALK_EV:
            begin
                cmd.op     = OP_WALK_EV;
                state_next = flags.rd_pos ? S_MCHK : S_WALK;
            end
            S_MCHK:
            begin
                if (flags.merge_ok)
                begin
                    cmd.op     = OP_MERGE_RD;
                    state_next = S_MEV;
                end
                else
                    state_next = S_FIT;
            end
            S_MEV:
            begin
                cmd.op     = OP_MERGE_EV;
                state_next = flags.rd_pos ? S_MCHK : S_FIT;
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                state_next = flags.fit ? S_MB1 : S_WALK;
            end
            S_GNEED:
            begin
                cmd.op     = OP_GNEED;
                state_next = S_GSTEP;
            end
            S_GSTEP:
            begin
                if (flags.grow_over)
                    state_next = S_RST;
                else if (flags.grow_short)
                    cmd.op = OP_GSTEP;
                else
                    state_next = S_GW1;
            end
            S_GW1:
            begin
                cmd.op     = OP_GW1;
                state_next = S_GW2;
            end
            S_GW2:
            begin
                cmd.op     = OP_GW2;
                state_next = S_GW3;
            end
            S_GW3:
            begin
                cmd.op     = OP_GW3;
                state_next = S_FF_START;
            end
            S_MB1:
            begin
                cmd.op     = OP_MB1;
                state_next = S_MB2;
            end
            S_MB2:
            begin
                cmd.op     = OP_MB2;
                state_next = flags.p_is_ff ? S_FFA : S_FIN;
            end
            S_FFA:
            begin
                if (flags.ff_lt_sent)
                begin
                    cmd.op     = OP_FFA_RD;
                    state_next = S_FFA_EV;
                end
                else
                    state_next = S_FIN;
            end
            S_FFA_EV:
            begin
                cmd.op     = OP_FFA_EV;
                state_next = flags.rd_neg ? S_FFA : S_FIN;
            end
            S_RST:
            begin
                if (flags.jptr_zero)
                begin
                    cmd.op     = OP_RST_DONE;
                    cmd.st_we  = 1'b1;
                    cmd.st_val = ST_EXHAUSTED;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_RST_RD;
                    state_next = S_RST_WR;
                end
            end
            S_RST_WR:
            begin
                cmd.op     = OP_RST_WR;
                state_next = S_RST;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* rtl/core/ffba_datapath.sv */
// Header store, undo journal and working registers of the first-fit allocator.
// Depends on ffba_pkg; carries out the operations issued by ffba_ctrl.
`default_nettype none
module ffba_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ffba_pkg::cmd_t                  cmd,
    output ffba_pkg::flags_t                     flags,
    input  wire logic [ffba_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [ffba_pkg::IDX_W-1:0]      in_handle,
    input  wire logic [ffba_pkg::BYTES_W-1:0]    in_bytes,
    input  wire logic                            cfg_we,
    input  wire logic [ffba_pkg::LIM_W-1:0]      cfg_wdata,
    output logic                                 done,
    output logic [ffba_pkg::IDX_W-1:0]           result_handle,
    output logic [ffba_pkg::ST_W-1:0]            status,
    output logic [ffba_pkg::IDX_W-1:0]           copy_source,
    output logic [ffba_pkg::IDX_W-1:0]           copy_target,
    output logic [ffba_pkg::IDX_W-1:0]           copy_cells
);
    import ffba_pkg::*;

    typedef logic signed [SW_W-1:0] sw_t;

    // Memories
    logic [HDR_W-1:0] hdr_mem [0:POOL_CELLS-1];
    logic [JRN_W-1:0] jrn_mem [0:POOL_CELLS-1];

    // Control registers
    logic [IDX_W-1:0]  ff_reg, sent_reg, save_ff_reg, save_sent_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [JPTR_W-1:0] jptr_reg;
    logic              jrn_on_reg, done_reg, c0_wr_reg;

    // Working registers
    logic [KIND_W-1:0]       kind_reg;
    logic [IDX_W-1:0]        handle_reg, h_reg, p_reg, np_reg, q_reg, last_reg;
    logic [NW_W-1:0]         nw_reg;
    logic                    bz_reg, valid_reg, is_last_reg;
    logic signed [LEN_W-1:0] lp_reg, last_len_reg;
    logic [CNT_W-1:0]        need_reg, cells_reg;
    sw_t                     old_reg;
    logic [IDX_W-1:0]        res_reg, cs_reg, ct_reg, cc_reg;
    logic [ST_W-1:0]         st_reg;

    // Read side
    logic [HDR_W-1:0] rd_q, rd_hdr;
    logic             rd_c0_reg;
    logic [JRN_W-1:0] jrd_q;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_next;
    logic signed [LEN_W-1:0] rd_len;

    // Write side
    logic             wr_en, jw_en;
    logic [IDX_W-1:0] wr_addr;
    logic [HDR_W-1:0] wr_data;
    logic [JRN_W-1:0] jw_data;

    // Derived values
    logic             valid_in;
    logic [NW_W-1:0]  nw_in;
    logic [IDX_W-1:0] jptr_m1;
    logic [IDX_W-1:0] fol_p, fol_q, q_split, ns;
    logic [LIM_W:0]   b_w;
    logic [CNT_W:0]   grow_end;
    logic [LIM_W-1:0] lim;
    sw_t              nw_s, lp_s, rdl_s, last_s, need_s, rd_abs, p_plus_lp;

    assign rd_hdr  = rd_c0_reg ? SENT_HDR : rd_q;
    assign rd_next = rd_hdr[HDR_W-1:LEN_W];
    assign rd_len  = $signed(rd_hdr[LEN_W-1:0]);

    assign valid_in = (in_handle != '0) && ((in_handle - 1'b1) < sent_reg);
    assign nw_in    = NW_W'(({1'b0, in_bytes} + (BYTES_W+1)'(CELL_BYTES - 1)) >> CELL_SHIFT);
    assign jptr_m1  = IDX_W'(jptr_reg - 1'b1);

    assign nw_s      = sw_t'({{(SW_W-NW_W){1'b0}}, nw_reg});
    assign lp_s      = sw_t'(lp_reg);
    assign rdl_s     = sw_t'(rd_len);
    assign last_s    = sw_t'(last_len_reg);
    assign rd_abs    = (rdl_s < 0) ? -rdl_s : rdl_s;
    assign p_plus_lp = sw_t'({{(SW_W-IDX_W){1'b0}}, p_reg}) + lp_s;

    assign fol_p   = follow(p_reg, (cmd.op == OP_MB1) ? np_reg : rd_next, sent_reg);
    assign fol_q   = follow(q_reg, rd_next, sent_reg);
    assign q_split = IDX_W'(p_reg + nw_reg + 1'b1);

    assign lim      = (limit_reg < LIM_W'(POOL_CELLS)) ? limit_reg : LIM_W'(POOL_CELLS);
    assign b_w      = {1'b0, sent_reg} + 1'b1;
    assign grow_end = (CNT_W+1)'(b_w) + (CNT_W+1)'(cells_reg);
    assign ns       = IDX_W'(grow_end - 1'b1);

    assign need_s = (last_s > 0) ? (nw_s + 1 - last_s) : (nw_s + 1);

    // Status back to the sequencer
    always_comb
    begin
        flags.kind       = kind_reg;
        flags.bytes_zero = bz_reg;
        flags.valid      = valid_reg;
        flags.p_ge_sent  = (p_reg >= sent_reg);
        flags.rd_pos     = (rd_len > 0);
        flags.rd_neg     = (rd_len < 0);
        flags.merge_ok   = (p_plus_lp == sw_t'({{(SW_W-IDX_W){1'b0}}, q_reg}))
                           && (q_reg < sent_reg);
        flags.fit        = (nw_s < lp_s);
        flags.grow_over  = (grow_end > (CNT_W+1)'(lim));
        flags.grow_short = (cells_reg < need_reg);
        flags.tr_big     = (nw_s > (-rdl_s - 1));
        flags.p_is_ff    = (p_reg == ff_reg);
        flags.ff_lt_sent = (ff_reg < sent_reg);
        flags.jptr_zero  = (jptr_reg == '0);
    end

    // Pick the read address
    always_comb
    begin
        case (cmd.op)
            OP_REL_RD, OP_TR_RD: rd_addr = h_reg;
            OP_MERGE_RD:         rd_addr = q_reg;
            OP_FFA_RD:           rd_addr = ff_reg;
            default:             rd_addr = p_reg;
        endcase
    end

    // Drive the header write port and the journal
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_reg;
        wr_data = '0;
        jw_en   = 1'b0;
        jw_data = '0;
        case (cmd.op)
            OP_REL_EV:
            begin
                wr_en   = (rd_len < 0);
                wr_addr = h_reg;
                wr_data = {rd_next, LEN_W'(-rd_len)};
                jw_en   = jrn_on_reg && (rd_len < 0);
                jw_data = {h_reg, rd_hdr};
            end
            OP_MERGE_EV:
            begin
                wr_en   = (rd_len > 0);
                wr_data = {fol_q, LEN_W'(lp_reg + rd_len)};
                jw_en   = jrn_on_reg && (rd_len > 0);
                jw_data = {p_reg, np_reg, lp_reg};
            end
            OP_GW1:
            begin
                wr_en   = 1'b1;
                wr_addr = sent_reg;
                wr_data = {IDX_W'(b_w), LEN_W'(1)};
                jw_en   = jrn_on_reg;
                jw_data = {sent_reg, sent_reg, {LEN_W{1'b1}}};
            end
            OP_GW2:
            begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(b_w);
                wr_data = {ns, LEN_W'(cells_reg - 1'b1)};
            end
            OP_GW3:
            begin
                wr_en   = 1'b1;
                wr_addr = ns;
                wr_data = {ns, {LEN_W{1'b1}}};
            end
            OP_MB1:
            begin
                wr_en   = flags.fit && (lp_s > nw_s + 1);
                wr_addr = q_split;
                wr_data = {fol_p, LEN_W'(lp_s - nw_s - 1)};
            end
            OP_MB2:
            begin
                wr_en   = 1'b1;
                wr_data = {np_reg, LEN_W'(-lp_reg)};
            end
            OP_RST_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = jrd_q[JRN_W-1:HDR_W];
                wr_data = jrd_q[HDR_W-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Header store and journal arrays
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hdr_mem[wr_addr] <= wr_data;
        rd_q <= hdr_mem[rd_addr];
        if (jw_en)
            jrn_mem[jptr_reg[IDX_W-1:0]] <= jw_data;
        jrd_q <= jrn_mem[jptr_m1];
    end

    // Control state: pointers, limit, journal fill and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg        <= '0;
            sent_reg      <= '0;
            save_ff_reg   <= '0;
            save_sent_reg <= '0;
            limit_reg     <= LIM_W'(8192);
            jptr_reg      <= '0;
            jrn_on_reg    <= 1'b0;
            done_reg      <= 1'b0;
            c0_wr_reg     <= 1'b0;
            rd_c0_reg     <= 1'b0;
        end
        else
        begin
            done_reg  <= (cmd.op == OP_FIN);
            rd_c0_reg <= (rd_addr == '0) && !c0_wr_reg;
            if (wr_en && wr_addr == '0)
                c0_wr_reg <= 1'b1;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (jw_en)
                jptr_reg <= jptr_reg + 1'b1;
            case (cmd.op)
                OP_LOAD:
                    jrn_on_reg <= 1'b0;
                OP_SNAP:
                begin
                    save_ff_reg   <= ff_reg;
                    save_sent_reg <= sent_reg;
                    jptr_reg      <= '0;
                    jrn_on_reg    <= 1'b1;
                end
                OP_REL_EV:
                begin
                    if (h_reg < ff_reg)
                        ff_reg <= h_reg;
                end
                OP_GW3:
                    sent_reg <= ns;
                OP_FFA_EV:
                begin
                    if (rd_len < 0)
                        ff_reg <= follow(ff_reg, rd_next, sent_reg);
                end
                OP_RST_RD:
                    jptr_reg <= jptr_reg - 1'b1;
                OP_RST_DONE:
                begin
                    ff_reg   <= save_ff_reg;
                    sent_reg <= save_sent_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.st_we)
            st_reg <= cmd.st_val;
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg   <= (in_kind == K_RESIZE && !valid_in) ? K_ALLOC : in_kind;
                handle_reg <= in_handle;
                h_reg      <= valid_in ? IDX_W'(in_handle - 1'b1) : '0;
                nw_reg     <= nw_in;
                bz_reg     <= (in_bytes == '0);
                valid_reg  <= valid_in;
                res_reg    <= '0;
                cs_reg     <= '0;
                ct_reg     <= '0;
                cc_reg     <= '0;
                st_reg     <= ST_OK;
                old_reg    <= '0;
            end
            OP_REL_EV:
                old_reg <= ((rd_abs - 1) < nw_s) ? (rd_abs - 1) : nw_s;
            OP_TR_EV:
            begin
                p_reg  <= h_reg;
                lp_reg <= -rd_len;
                np_reg <= rd_next;
            end
            OP_FF_START:
            begin
                p_reg        <= ff_reg;
                last_reg     <= sent_reg;
                last_len_reg <= {LEN_W{1'b1}};
            end
            OP_WALK_EV:
            begin
                if (rd_len <= 0)
                    p_reg <= fol_p;
                else
                begin
                    lp_reg      <= rd_len;
                    np_reg      <= rd_next;
                    q_reg       <= fol_p;
                    is_last_reg <= (fol_p == sent_reg);
                end
            end
            OP_MERGE_EV:
            begin
                if (rd_len > 0)
                begin
                    lp_reg <= LEN_W'(lp_reg + rd_len);
                    np_reg <= fol_q;
                    q_reg  <= fol_q;
                end
            end
            OP_FIT:
            begin
                if (is_last_reg)
                begin
                    last_reg     <= p_reg;
                    last_len_reg <= lp_reg;
                end
                if (!flags.fit)
                    p_reg <= q_reg;
            end
            OP_GNEED:
            begin
                need_reg  <= (need_s < 1) ? CNT_W'(1) : CNT_W'(need_s);
                cells_reg <= CNT_W'(GROW_CELLS);
            end
            OP_GSTEP:
                cells_reg <= cells_reg + CNT_W'(GROW_CELLS);
            OP_MB1:
            begin
                if (lp_s > nw_s + 1)
                begin
                    np_reg <= q_split;
                    lp_reg <= LEN_W'(nw_s + 1);
                end
            end
            OP_MB2:
            begin
                res_reg <= IDX_W'(p_reg + 1'b1);
                if (kind_reg == K_RESIZE && p_reg != h_reg && old_reg > 0)
                begin
                    cs_reg <= handle_reg;
                    ct_reg <= IDX_W'(p_reg + 1'b1);
                    cc_reg <= IDX_W'(old_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done          = done_reg;
    assign result_handle = res_reg;
    assign status        = st_reg;
    assign copy_source   = cs_reg;
    assign copy_target   = ct_reg;
    assign copy_cells    = cc_reg;

    // The walk only reads headers below the sentinel
    a_walk_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WALK_RD) |-> (p_reg < sent_reg))
        else $error("walk read past the sentinel");

    // The first-free pointer never passes the sentinel
    a_ff_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ff_reg <= sent_reg)
        else $error("first-free pointer beyond sentinel");

    // A block is marked busy only when it holds the request
    a_fit_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MB2) |-> (lp_s > nw_s))
        else $error("block too small on allocation");

    // The strobe follows the finishing step
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.op == OP_FIN))
        else $error("result strobe without finish");

endmodule
`default_nettype wire
